FILE: hw/rtl/tesp_pkg.sv
// tesp_pkg: types, codes and helpers for the terminal escape sequence parser
// used by tesp_core and terminal_escape_sequence_parser; no dependencies
`default_nettype none

package tesp_pkg;

	// width of the first csi parameter accumulator
	localparam int PARAM_BITS = 16;
	localparam int PARAM_EXT  = PARAM_BITS + 4;
	localparam int CNT_EXT    = PARAM_BITS + 16;

	localparam logic [PARAM_BITS-1:0] PARAM_MAX = {PARAM_BITS{1'b1}};

	// control bytes
	localparam logic [7:0] C_BEL = 8'h07;
	localparam logic [7:0] C_BS  = 8'h08;
	localparam logic [7:0] C_TAB = 8'h09;
	localparam logic [7:0] C_LF  = 8'h0A;
	localparam logic [7:0] C_VT  = 8'h0B;
	localparam logic [7:0] C_FF  = 8'h0C;
	localparam logic [7:0] C_CR  = 8'h0D;
	localparam logic [7:0] C_SO  = 8'h0E;
	localparam logic [7:0] C_SI  = 8'h0F;
	localparam logic [7:0] C_CAN = 8'h18;
	localparam logic [7:0] C_SUB = 8'h1A;
	localparam logic [7:0] C_ESC = 8'h1B;
	localparam logic [7:0] C_SP  = 8'h20;
	localparam logic [7:0] C_DEL = 8'h7F;
	localparam logic [7:0] C_CSI = 8'h9B;

	// screen action codes
	typedef enum logic [3:0] {
		A_NONE  = 4'd0,
		A_PRINT = 4'd1,
		A_BS    = 4'd2,
		A_TAB   = 4'd3,
		A_CR    = 4'd4,
		A_NL    = 4'd5,
		A_LF    = 4'd6,
		A_RLF   = 4'd7,
		A_INS   = 4'd8,
		A_PAL   = 4'd9
	} action_t;

	// parser modes, one-hot
	typedef enum logic [11:0] {
		M_NORMAL = 12'b0000_0000_0001,
		M_ESC    = 12'b0000_0000_0010,
		M_CSI    = 12'b0000_0000_0100,
		M_OSC    = 12'b0000_0000_1000,
		M_EAT    = 12'b0000_0001_0000,
		M_OSC4   = 12'b0000_0010_0000,
		M_OSC5   = 12'b0000_0100_0000,
		M_PAL    = 12'b0000_1000_0000,
		M_ESCNUM = 12'b0001_0000_0000,
		M_ESCPCT = 12'b0010_0000_0000,
		M_LPAREN = 12'b0100_0000_0000,
		M_RPAREN = 12'b1000_0000_0000
	} mode_t;

	// parser state carried from item to item
	typedef struct packed {
		mode_t                 mode;
		logic [PARAM_BITS-1:0] first_param;
		logic                  have_param;
		logic                  param_closed;
		logic [2:0]            hex_count;
		logic [3:0]            pend_index;
		logic [23:0]           pend_rgb;
	} state_t;

	// one result item
	typedef struct packed {
		logic        warn;
		logic [23:0] palette_rgb;
		logic [3:0]  palette_index;
		logic [15:0] blank_count;
		logic [7:0]  print_byte;
		action_t     action;
	} result_t;

	// state after a mode change: all parameter registers cleared
	function automatic state_t enter_mode(input mode_t m);
		state_t s;
		s = '0;
		s.mode = m;
		return s;
	endfunction

	// uppercase hex digit decode, bit 4 marks a valid digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tesp_core.sv
// tesp_core: next-state and result logic for one byte of the parser
// depends on tesp_pkg
`default_nettype none

module tesp_core
	import tesp_pkg::*;
(
	input  wire logic [7:0] in_byte,
	input  wire state_t     cur,
	output state_t          nxt,
	output result_t         res
);

	logic                  ctrl;
	logic                  done;
	logic [4:0]            hex;
	logic [2:0]            hex_cnt;
	logic [23:0]           rgb_next;
	logic [PARAM_EXT-1:0]  acc;
	logic [CNT_EXT-1:0]    cnt_ext;

	// shared arithmetic pieces
	always_comb begin
		hex      = hex_decode(in_byte);
		hex_cnt  = cur.hex_count + 3'd1;
		rgb_next = {cur.pend_rgb[19:0], hex[3:0]};
		acc      = (PARAM_EXT'(cur.first_param) << 3) + (PARAM_EXT'(cur.first_param) << 1)
			+ PARAM_EXT'(in_byte[3:0]);
		cnt_ext  = cur.have_param ? CNT_EXT'(cur.first_param) : CNT_EXT'(1);
	end

	// byte decode per mode
	always_comb begin
		nxt  = cur;
		res  = '0;
		done = 1'b0;
		ctrl = (cur.mode != M_EAT)
			&& (in_byte < C_SP || in_byte == C_DEL || in_byte == C_CSI);

		// control bytes act in every mode but eat
		if (ctrl) begin
			done = 1'b1;
			case (in_byte)
				C_BEL, C_DEL: ;
				C_BS: res.action = A_BS;
				C_TAB: res.action = A_TAB;
				C_LF, C_VT, C_FF: res.action = A_NL;
				C_CR: res.action = A_CR;
				C_SO, C_SI: res.warn = 1'b1;
				C_CAN, C_SUB: nxt = enter_mode(M_NORMAL);
				C_ESC: nxt = enter_mode(M_ESC);
				C_CSI: nxt = enter_mode(M_CSI);
				default: done = 1'b0;
			endcase
		end

		if (!done) begin
			case (cur.mode)
				M_ESC: begin
					nxt = enter_mode(M_NORMAL);
					case (in_byte)
						"c", "Z", ">", "=": ;
						"D": res.action = A_LF;
						"E": res.action = A_NL;
						"M": res.action = A_RLF;
						"H", "7", "8": res.warn = 1'b1;
						"[": nxt = enter_mode(M_CSI);
						"%": nxt = enter_mode(M_ESCPCT);
						"#": nxt = enter_mode(M_ESCNUM);
						"(": nxt = enter_mode(M_LPAREN);
						")": nxt = enter_mode(M_RPAREN);
						"]": nxt = enter_mode(M_OSC);
						default: res.warn = 1'b1;
					endcase
				end
				M_CSI: begin
					if (in_byte >= "0" && in_byte <= "9") begin
						// digits only count toward the first parameter
						if (!cur.param_closed) begin
							nxt.first_param = (acc > PARAM_EXT'(PARAM_MAX)) ? PARAM_MAX
								: acc[PARAM_BITS-1:0];
							nxt.have_param  = 1'b1;
						end
					end else if (in_byte == ";") begin
						nxt.have_param   = 1'b1;
						nxt.param_closed = 1'b1;
					end else if (in_byte == "@") begin
						res.action      = A_INS;
						res.blank_count = (cnt_ext > CNT_EXT'(16'hFFFF)) ? 16'hFFFF
							: cnt_ext[15:0];
						res.warn        = cur.param_closed;
						nxt             = enter_mode(M_NORMAL);
					end else if (in_byte >= 8'h40 && in_byte <= 8'h7E) begin
						res.warn = 1'b1;
						nxt      = enter_mode(M_NORMAL);
					end else begin
						res.warn = 1'b1;
					end
				end
				M_ESCPCT, M_ESCNUM, M_LPAREN, M_RPAREN: begin
					res.warn = 1'b1;
					nxt      = enter_mode(M_NORMAL);
				end
				M_OSC: begin
					nxt = enter_mode(M_NORMAL);
					case (in_byte)
						"P": nxt = enter_mode(M_PAL);
						"0", "1", "2": nxt = enter_mode(M_EAT);
						"4": nxt = enter_mode(M_OSC4);
						"5": nxt = enter_mode(M_OSC5);
						default: res.warn = 1'b1;
					endcase
				end
				M_EAT: begin
					if (in_byte == C_BEL) begin
						nxt = enter_mode(M_NORMAL);
					end
				end
				M_OSC4: begin
					res.warn = (in_byte != "6");
					nxt      = enter_mode(M_EAT);
				end
				M_OSC5: begin
					res.warn = (in_byte != "0");
					nxt      = enter_mode(M_EAT);
				end
				M_PAL: begin
					// first digit is the index, then six rgb digits
					if (!hex[4]) begin
						res.warn = 1'b1;
					end else begin
						nxt.hex_count = hex_cnt;
						if (hex_cnt == 3'd1) begin
							nxt.pend_index = hex[3:0];
						end else begin
							nxt.pend_rgb = rgb_next;
							if (hex_cnt == 3'd7) begin
								res.action        = A_PAL;
								res.palette_index = cur.pend_index;
								res.palette_rgb   = rgb_next;
								nxt               = enter_mode(M_NORMAL);
							end
						end
					end
				end
				default: begin
					res.action     = A_PRINT;
					res.print_byte = in_byte;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/terminal_escape_sequence_parser.sv
// terminal_escape_sequence_parser: top level, input register, parser state and result register
// depends on tesp_pkg and tesp_core
// an accepted input item passes the input register and then the result register to the master side
// throughput: one item per cycle while the master side does not stall, set by the single parser state update per byte
// reset: arst_n clears both valid flags and returns the parser to normal text mode
`default_nettype none

module terminal_escape_sequence_parser
	import tesp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // [3:0] action, [11:4] print_byte,
	                                    // [27:12] blank_count, [31:28] palette_index,
	                                    // [55:32] palette_rgb
	output logic             m_tuser    // [0] warn
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	result_t     out_q;
	state_t      state_q;
	state_t      state_nxt;
	result_t     res;
	logic        advance;

	// the registered byte moves on whenever the result register is free or drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	tesp_core u_core (
		.in_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	// parser state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= enter_mode(M_NORMAL);
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.palette_rgb, out_q.palette_index, out_q.blank_count,
		out_q.print_byte, out_q.action};
	assign m_tuser  = out_q.warn;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for terminal_escape_sequence_parser, terminal bytes in,
// one screen action item out per byte, checked against an in-bench parser model
// depends on tesp_pkg and the parser rtl

module testbench;
	import tesp_pkg::*;

	localparam int MAX_GAP        = 5;
	localparam int HOLD_CYCLES    = 64;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1300;

	// one expected screen action
	typedef struct {
		action_t     action;
		logic [7:0]  print_byte;
		logic [15:0] blank_count;
		logic [3:0]  palette_index;
		logic [23:0] palette_rgb;
		logic        warn;
	} screen_action_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;            // [3:0] action, [11:4] print_byte, [27:12] blank_count,
	                                 // [31:28] palette_index, [55:32] palette_rgb
	logic        m_tuser;            // [0] warn

	// mirror of the parser state
	mode_t                 pmode;
	logic [PARAM_BITS-1:0] first_param;
	logic                  have_param;
	logic                  param_closed;
	logic [2:0]            hex_count;
	logic [3:0]            pend_index;
	logic [23:0]           pend_rgb;

	screen_action_t expected_actions[$];
	int errors       = 0;
	int bytes_sent   = 0;
	int idle_cycles  = 0;
	bit idle_on      = 1'b1;
	bit hold_request = 1'b0;

	terminal_escape_sequence_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// mode change clears every parameter register
	function automatic void change_mode(input mode_t m);
		pmode        = m;
		first_param  = '0;
		have_param   = 1'b0;
		param_closed = 1'b0;
		hex_count    = '0;
		pend_index   = '0;
		pend_rgb     = '0;
	endfunction

	// advance the parser mirror by one byte and queue the action it gives
	task automatic predict_action(input logic [7:0] c);
		screen_action_t        r;
		logic                  handled;
		logic [PARAM_BITS+3:0] acc;
		logic [31:0]           n;
		logic                  hex_ok;
		logic [3:0]            hex_val;
		mode_t                 next_mode;
		r.action        = A_NONE;
		r.print_byte    = '0;
		r.blank_count   = '0;
		r.palette_index = '0;
		r.palette_rgb   = '0;
		r.warn          = 1'b0;
		handled         = 1'b0;
		// control bytes, decoded everywhere but while eating osc text
		if (pmode != M_EAT && (c < C_SP || c == C_DEL || c == C_CSI)) begin
			handled = 1'b1;
			case (c)
				C_BEL, C_DEL: ;
				C_BS: r.action = A_BS;
				C_TAB: r.action = A_TAB;
				C_LF, C_VT, C_FF: r.action = A_NL;
				C_CR: r.action = A_CR;
				C_SO, C_SI: r.warn = 1'b1;
				C_CAN, C_SUB: change_mode(M_NORMAL);
				C_ESC: change_mode(M_ESC);
				C_CSI: change_mode(M_CSI);
				default: handled = 1'b0;
			endcase
		end
		if (!handled) begin
			case (pmode)
				M_ESC: begin
					next_mode = M_NORMAL;
					case (c)
						"c", "Z", ">", "=": ;
						"D": r.action = A_LF;
						"E": r.action = A_NL;
						"M": r.action = A_RLF;
						"H", "7", "8": r.warn = 1'b1;
						"[": next_mode = M_CSI;
						"%": next_mode = M_ESCPCT;
						"#": next_mode = M_ESCNUM;
						"(": next_mode = M_LPAREN;
						")": next_mode = M_RPAREN;
						"]": next_mode = M_OSC;
						default: r.warn = 1'b1;
					endcase
					change_mode(next_mode);
				end
				M_CSI: begin
					if (c >= "0" && c <= "9") begin
						// only the first parameter accumulates, saturating
						if (!param_closed) begin
							acc = PARAM_EXT'(first_param * 10 + (c - "0"));
							first_param = (acc > PARAM_MAX) ? PARAM_MAX : acc[PARAM_BITS-1:0];
							have_param = 1'b1;
						end
					end else if (c == ";") begin
						have_param   = 1'b1;
						param_closed = 1'b1;
					end else if (c == "@") begin
						n = have_param ? 32'(first_param) : 32'd1;
						r.action      = A_INS;
						r.blank_count = (n > 32'hFFFF) ? 16'hFFFF : n[15:0];
						r.warn        = param_closed;
						change_mode(M_NORMAL);
					end else if (c >= 8'h40 && c <= 8'h7E) begin
						r.warn = 1'b1;
						change_mode(M_NORMAL);
					end else begin
						r.warn = 1'b1;
					end
				end
				M_ESCPCT, M_ESCNUM, M_LPAREN, M_RPAREN: begin
					r.warn = 1'b1;
					change_mode(M_NORMAL);
				end
				M_OSC: begin
					next_mode = M_NORMAL;
					case (c)
						"P": next_mode = M_PAL;
						"0", "1", "2": next_mode = M_EAT;
						"4": next_mode = M_OSC4;
						"5": next_mode = M_OSC5;
						default: r.warn = 1'b1;
					endcase
					change_mode(next_mode);
				end
				M_EAT: begin
					if (c == C_BEL) change_mode(M_NORMAL);
				end
				M_OSC4: begin
					if (c != "6") r.warn = 1'b1;
					change_mode(M_EAT);
				end
				M_OSC5: begin
					if (c != "0") r.warn = 1'b1;
					change_mode(M_EAT);
				end
				M_PAL: begin
					hex_ok  = 1'b0;
					hex_val = '0;
					if (c >= "0" && c <= "9") begin
						hex_ok  = 1'b1;
						hex_val = c[3:0];
					end else if (c >= "A" && c <= "F") begin
						hex_ok  = 1'b1;
						hex_val = 4'(c - "A" + 10);
					end
					// first digit is the index, six more make the color
					if (!hex_ok) begin
						r.warn = 1'b1;
					end else begin
						hex_count = hex_count + 3'd1;
						if (hex_count == 3'd1) begin
							pend_index = hex_val;
						end else begin
							pend_rgb = {pend_rgb[19:0], hex_val};
							if (hex_count == 3'd7) begin
								r.action        = A_PAL;
								r.palette_index = pend_index;
								r.palette_rgb   = pend_rgb;
								change_mode(M_NORMAL);
							end
						end
					end
				end
				default: begin
					r.action     = A_PRINT;
					r.print_byte = c;
				end
			endcase
		end
		expected_actions.insert(expected_actions.size(), r);
	endtask

	// offer one byte after a random gap, hold it until taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_action(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// palette command, cut short by a cancel when fewer than seven digits
	task automatic send_palette_command(input int digits);
		int i;
		int v;
		send_byte(C_ESC);
		send_text("]P");
		for (i = 0; i < digits; i++) begin
			if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(8'h20, 8'h7E)));
			v = $urandom_range(0, 15);
			send_byte((v < 10) ? 8'("0" + v) : 8'("A" + v - 10));
		end
		if (digits < 7) begin
			case ($urandom_range(0, 2))
				0: send_byte(C_CAN);
				1: send_byte(C_SUB);
				default: send_byte(C_ESC);
			endcase
		end
	endtask

	// csi with random parameters, half of the time ending in insert blanks
	task automatic send_csi_command();
		int i;
		int n;
		if ($urandom_range(0, 1)) send_byte(C_CSI);
		else send_text("\033[");
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
		for (i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(0, 9)));
		if ($urandom_range(0, 3) == 0) begin
			send_byte(";");
			n = $urandom_range(0, 3);
			for (i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(0, 9)));
		end
		if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(8'h20, 8'h2F)));
		case ($urandom_range(0, 5))
			0, 1, 2: send_byte("@");
			3: send_byte(8'($urandom_range(8'h40, 8'h7E)));
			4: send_byte(8'($urandom_range(8'h00, 8'hFF)));
			default: send_byte(C_CAN);
		endcase
	endtask

	// osc title or font command, text eaten up to bel
	task automatic send_osc_text();
		int i;
		int n;
		logic [7:0] b;
		send_text("\033]");
		case ($urandom_range(0, 5))
			0, 1, 2: send_byte(8'("0" + $urandom_range(0, 2)));
			3: begin
				send_byte("4");
				send_byte($urandom_range(0, 5) ? 8'("6") : 8'($urandom_range(0, 255)));
			end
			4: begin
				send_byte("5");
				send_byte($urandom_range(0, 5) ? 8'("0") : 8'($urandom_range(0, 255)));
			end
			default: send_byte(8'($urandom_range(8'h20, 8'h7E)));
		endcase
		n = $urandom_range(0, 10);
		for (i = 0; i < n; i++) begin
			do b = 8'($urandom_range(0, 255)); while (b == C_BEL);
			send_byte(b);
		end
		send_byte(C_BEL);
	endtask

	task automatic send_random_sequence();
		int i;
		int n;
		string esc_finals;
		string charset_leads;
		esc_finals    = "cZ>=DEMH78[]%#()";
		charset_leads = "%#()";
		case ($urandom_range(0, 11))
			// raw bytes of any value
			0: begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
			end
			// plain text
			1: begin
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++) send_byte(8'($urandom_range(8'h20, 8'h7E)));
			end
			// single control byte
			2: begin
				case ($urandom_range(0, 12))
					0: send_byte(C_BEL);
					1: send_byte(C_BS);
					2: send_byte(C_TAB);
					3: send_byte(C_LF);
					4: send_byte(C_VT);
					5: send_byte(C_FF);
					6: send_byte(C_CR);
					7: send_byte(C_SO);
					8: send_byte(C_SI);
					9: send_byte(C_CAN);
					10: send_byte(C_SUB);
					11: send_byte(C_DEL);
					default: send_byte(8'($urandom_range(8'h00, 8'h1F)));
				endcase
			end
			// two-byte escape
			3: begin
				send_byte(C_ESC);
				if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
				else send_byte(esc_finals[$urandom_range(0, esc_finals.len() - 1)]);
			end
			4, 5, 6: send_csi_command();
			7, 8: send_palette_command(7);
			9: send_osc_text();
			// charset or line attribute escape with its argument
			10: begin
				send_byte(C_ESC);
				send_byte(charset_leads[$urandom_range(0, charset_leads.len() - 1)]);
				send_byte(8'($urandom_range(0, 255)));
			end
			default: send_palette_command($urandom_range(0, 6));
		endcase
	endtask

	// control bytes at the field extremes
	task automatic test_controls();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(C_BS);
		send_byte(C_TAB);
		send_byte(C_LF);
		send_byte(C_CR);
		send_byte(C_SO);
		send_byte(C_DEL);
	endtask

	// escape newline and a charset escape eating one argument
	task automatic test_escapes();
		send_text("\033E");
		send_text("\033(B");
	endtask

	// default count, saturated count, extra parameter
	task automatic test_insert_blanks();
		send_byte(C_CSI);
		send_byte("@");
		send_text("\033[99999@");
		send_byte(C_CSI);
		send_text(";5@");
	endtask

	// palette entry at the top of every field
	task automatic test_palette();
		send_text("\033]PFFFFFFF");
	endtask

	// escape inside eaten text is dropped until bel
	task automatic test_osc_eating();
		send_text("\033]46");
		send_byte(C_ESC);
		send_byte(C_BEL);
	endtask

	// receiver stalls long while bytes keep coming
	task automatic test_backpressure();
		idle_on      = 1'b0;
		hold_request = 1'b1;
		send_text("output stalled while input keeps flowing");
		idle_on      = 1'b1;
	endtask

	task automatic test_random_stream();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_ITEMS) begin
			// every third stretch runs without idling
			idle_on = (((bytes_sent - start) / 200) % 3) != 2;
			send_random_sequence();
		end
		idle_on = 1'b1;
	endtask

	// receiver: random stall per item, long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_CYCLES;
			end else if (m_tvalid && m_tready) begin
				stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
	                                    input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// compare each result item with the oldest expectation
	always @(posedge clk) begin : check_results
		screen_action_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_actions.size() == 0) begin
				$error("result item with nothing expected: tdata 0x%0h", m_tdata);
				errors++;
			end else begin
				want = expected_actions.pop_front();
				check_field("action", 32'(want.action), 32'(m_tdata[3:0]));
				check_field("print_byte", 32'(want.print_byte), 32'(m_tdata[11:4]));
				check_field("blank_count", 32'(want.blank_count), 32'(m_tdata[27:12]));
				check_field("palette_index", 32'(want.palette_index), 32'(m_tdata[31:28]));
				check_field("palette_rgb", 32'(want.palette_rgb), 32'(m_tdata[55:32]));
				check_field("warn", 32'(want.warn), 32'(m_tuser));
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// test sequence
	initial begin
		change_mode(M_NORMAL);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_controls();
		test_escapes();
		test_insert_blanks();
		test_palette();
		test_osc_eating();
		test_backpressure();
		test_random_stream();
		s_tvalid <= 1'b0;
		while (expected_actions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
